// File: sv/assert_macros.svh
// Assertion macros shared by the polynomial term store RTL.
// Every check is sampled on i_clk and held off while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational or implication property that must hold at every edge.
`define SPTS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define SPTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/spts_pkg.sv
// Shared types and constants for the sparse polynomial term store.
// No dependencies; imported by the cell, the max tree and the top level.
`default_nettype none

package spts_pkg;

    localparam int EXP_W     = 16;
    localparam int COEF_W    = 32;
    localparam int POS_W     = 6;
    localparam int CNT_OUT_W = 7;

    // Slave tdata layout, lowest bit first
    localparam int IN_CLR_LSB  = 0;
    localparam int IN_NEG_LSB  = 1;
    localparam int IN_COEF_LSB = 2;
    localparam int IN_EXP_LSB  = IN_COEF_LSB + COEF_W;
    localparam int IN_POS_LSB  = IN_EXP_LSB + EXP_W;
    localparam int IN_DATA_W   = 56;

    // Master tdata: coef, exponent, count, degree, empty flag
    localparam int OUT_DATA_W  = COEF_W + EXP_W + CNT_OUT_W + EXP_W + 1;

    typedef enum logic {
        OP_PUT  = 1'b0,
        OP_READ = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_TREE,
        S_OUT
    } t_state;

    // Strobes broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;
        logic apply;
        logic op_read;
        logic update;
        logic remove;
        logic insert;
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: sv/spts_cell.sv
// One list slot of the term store: exponent and coefficient, match flag.
// Depends on spts_pkg; neighbors pass term data, a hit prefix and a gather bus.
`default_nettype none

module spts_cell import spts_pkg::*; #(
    parameter int CNT_W = 7,
    parameter int IDX   = 0
) (
    input  wire                     i_clk,
    input  t_cell_ctl               i_ctl,
    input  wire [CNT_W-1:0]         i_cnt,
    input  wire [EXP_W-1:0]         i_cmp_exp,
    input  wire [POS_W-1:0]         i_cmp_pos,
    input  wire [COEF_W-1:0]        i_new_coef,
    input  wire [EXP_W-1:0]         i_lo_exp,
    input  wire [COEF_W-1:0]        i_lo_coef,
    input  wire [EXP_W-1:0]         i_up_exp,
    input  wire [COEF_W-1:0]        i_up_coef,
    input  wire                     i_hit_pre,
    input  wire [EXP_W-1:0]         i_gath_exp,
    input  wire [COEF_W-1:0]        i_gath_coef,
    output logic [EXP_W-1:0]        o_exp,
    output logic [COEF_W-1:0]       o_coef,
    output logic                    o_hit,
    output logic                    o_hit_pre,
    output logic [EXP_W-1:0]        o_gath_exp,
    output logic [COEF_W-1:0]       o_gath_coef,
    output logic [EXP_W-1:0]        o_leaf
);

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);
    localparam bit               POS_OK = (IDX < (1 << POS_W));
    localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

    logic [EXP_W-1:0]  r_exp;
    logic [COEF_W-1:0] r_coef;
    logic              r_hit;
    logic              n_hit;
    logic              w_occ;
    logic [COEF_W-1:0] w_sum;
    logic [COEF_W-1:0] w_pick;

    assign w_occ = (MY_IDX < i_cnt);
    assign w_sum = r_coef + i_new_coef;

    always_comb begin
        if (i_ctl.op_read) begin
            n_hit = POS_OK && (i_cmp_pos == MY_POS) && w_occ;
        end else begin
            n_hit = w_occ && (r_exp == i_cmp_exp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_hit <= n_hit;
        end
    end

    // Update adds to the hit slot; remove closes the gap from the hit slot on; insert pushes everything down.
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            if (i_ctl.update && r_hit) begin
                r_coef <= w_sum;
            end else if (i_ctl.remove && (i_hit_pre || r_hit)) begin
                r_exp  <= i_up_exp;
                r_coef <= i_up_coef;
            end else if (i_ctl.insert) begin
                r_exp  <= i_lo_exp;
                r_coef <= i_lo_coef;
            end
        end
    end

    assign w_pick      = i_ctl.op_read ? r_coef : w_sum;
    assign o_exp       = r_exp;
    assign o_coef      = r_coef;
    assign o_hit       = r_hit;
    assign o_hit_pre   = i_hit_pre | r_hit;
    assign o_gath_exp  = i_gath_exp | (r_hit ? r_exp : '0);
    assign o_gath_coef = i_gath_coef | (r_hit ? w_pick : '0);
    assign o_leaf      = w_occ ? r_exp : '0;

endmodule

`default_nettype wire

// File: sv/spts_max_tree.sv
// Registered binary max tree over the exponents of the occupied slots.
// Depends on spts_pkg; each tree level is registered, and the root is the last level.
`default_nettype none

module spts_max_tree import spts_pkg::*; #(
    parameter int NUM = 64
) (
    input  wire                 i_clk,
    input  wire [EXP_W-1:0]     i_leaf [NUM],
    output logic [EXP_W-1:0]    o_max
);

    localparam int LVL = $clog2(NUM);
    localparam int P   = 1 << LVL;

    logic [EXP_W-1:0] r_node [P-1];
    logic [EXP_W-1:0] w_all  [2*P-1];

    genvar k;
    generate
        for (k = 0; k < 2*P-1; k++) begin : g_all
            if (k < P-1) begin : g_int
                assign w_all[k] = r_node[k];
            end else if (k - (P-1) < NUM) begin : g_leaf
                assign w_all[k] = i_leaf[k-(P-1)];
            end else begin : g_pad
                assign w_all[k] = '0;
            end
        end
        for (k = 0; k < P-1; k++) begin : g_node
            always_ff @(posedge i_clk) begin
                r_node[k] <= (w_all[2*k+1] > w_all[2*k+2]) ? w_all[2*k+1] : w_all[2*k+2];
            end
        end
    endgenerate

    assign o_max = r_node[0];

endmodule

`default_nettype wire

// File: sv/sparse_polynomial_term_store.sv
// Timing: an input beat is compared in the cells, applied, then waits in S_TREE
// for the registered degree tree to settle before m_axis_tvalid rises.
// A new item is taken only after the output has been accepted; the registered
// max tree over all slots sets the wait in S_TREE.
// Reset: synchronous, active low; empties the store, no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module sparse_polynomial_term_store import spts_pkg::*; #(
    parameter int MAX_TERMS = 64
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    // clear_first[0], negate[1], coef_in[33:2], exponent_in[49:34], position[55:50]
    input  wire [IN_DATA_W-1:0]     s_axis_tdata,
    // op[0]
    input  wire                     s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // coef_out[31:0], exponent_out[47:32], term_count[54:48], degree[70:55],
    // is_empty[71]
    output logic [OUT_DATA_W-1:0]   m_axis_tdata,
    // status[1:0]
    output logic [1:0]              m_axis_tuser
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int LVL   = $clog2(MAX_TERMS);
    localparam int WT_W  = $clog2(LVL + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_TERMS);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [WT_W-1:0]    r_wait;
    logic               r_op;
    logic [EXP_W-1:0]   r_e;
    logic [COEF_W-1:0]  r_c;
    logic [COEF_W-1:0]  r_cout, n_cout;
    logic [EXP_W-1:0]   r_eout, n_eout;
    t_status            r_status, n_status;

    logic               w_in_acc;
    logic               w_in_clr;
    logic               w_in_neg;
    logic [COEF_W-1:0]  w_in_coef;
    logic [EXP_W-1:0]   w_in_exp;
    logic [POS_W-1:0]   w_in_pos;
    logic [CNT_W-1:0]   w_cnt;
    logic               w_any_hit;
    logic [EXP_W-1:0]   w_degree;
    t_cell_ctl          w_ctl;

    logic [EXP_W-1:0]   w_exp    [MAX_TERMS];
    logic [COEF_W-1:0]  w_coef   [MAX_TERMS];
    logic [EXP_W-1:0]   w_leaf   [MAX_TERMS];
    logic               w_pre    [MAX_TERMS+1];
    logic [EXP_W-1:0]   w_gath_e [MAX_TERMS+1];
    logic [COEF_W-1:0]  w_gath_c [MAX_TERMS+1];
    logic [MAX_TERMS-1:0] w_hits;

    assign w_in_acc  = s_axis_tvalid & s_axis_tready;
    assign w_in_clr  = s_axis_tdata[IN_CLR_LSB];
    assign w_in_neg  = s_axis_tdata[IN_NEG_LSB];
    assign w_in_coef = s_axis_tdata[IN_COEF_LSB +: COEF_W];
    assign w_in_exp  = s_axis_tdata[IN_EXP_LSB +: EXP_W];
    assign w_in_pos  = s_axis_tdata[IN_POS_LSB +: POS_W];

    // Cells compare against the count after an optional clear
    assign w_cnt = (r_state == S_IDLE && w_in_clr) ? '0 : r_count;

    assign w_pre[0]    = 1'b0;
    assign w_gath_e[0] = '0;
    assign w_gath_c[0] = '0;
    assign w_any_hit   = w_pre[MAX_TERMS];

    // ---- next state ----
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_APPLY;
            S_APPLY: n_state = S_TREE;
            S_TREE:  if (r_wait == '0) n_state = S_OUT;
            S_OUT:   if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---- state outputs ----
    always_comb begin
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        w_ctl         = '0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_ctl.cmp     = w_in_acc;
                w_ctl.op_read = (s_axis_tuser == OP_READ);
            end
            S_APPLY: begin
                w_ctl.apply   = 1'b1;
                w_ctl.op_read = (r_op == OP_READ);
                w_ctl.update  = (r_op == OP_PUT) && w_any_hit && (w_gath_c[MAX_TERMS] != '0);
                w_ctl.remove  = (r_op == OP_PUT) && w_any_hit && (w_gath_c[MAX_TERMS] == '0);
                w_ctl.insert  = (r_op == OP_PUT) && !w_any_hit && (r_c != '0)
                                && (r_count != FULL_CNT);
            end
            S_TREE: w_ctl.op_read = (r_op == OP_READ);
            S_OUT: begin
                m_axis_tvalid = 1'b1;
                w_ctl.op_read = (r_op == OP_READ);
            end
            default: w_ctl = '0;
        endcase
    end

    // ---- result of the apply cycle ----
    always_comb begin
        n_count  = r_count;
        n_cout   = '0;
        n_eout   = '0;
        n_status = ST_OK;
        if (r_op == OP_READ) begin
            if (w_any_hit) begin
                n_cout = w_gath_c[MAX_TERMS];
                n_eout = w_gath_e[MAX_TERMS];
            end else begin
                n_status = ST_RANGE;
            end
        end else begin
            n_eout = r_e;
            if (w_any_hit) begin
                n_cout = w_gath_c[MAX_TERMS];
                if (w_ctl.remove) n_count = r_count - 1'b1;
            end else if (r_c != '0) begin
                if (r_count == FULL_CNT) begin
                    n_status = ST_FULL;
                end else begin
                    n_cout  = r_c;
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wait  <= '0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_count <= w_cnt;
            end else if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
            if (r_state == S_APPLY) begin
                r_wait <= WT_W'(LVL - 1);
            end else if (r_state == S_TREE) begin
                r_wait <= r_wait - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_op <= s_axis_tuser;
            r_e  <= w_in_exp;
            r_c  <= w_in_neg ? (COEF_W'(0) - w_in_coef) : w_in_coef;
        end
        if (r_state == S_APPLY) begin
            r_cout   <= n_cout;
            r_eout   <= n_eout;
            r_status <= n_status;
        end
    end

    // ---- row of cells, slot 0 is the newest term ----
    genvar g;
    generate
        for (g = 0; g < MAX_TERMS; g++) begin : g_cell
            logic [EXP_W-1:0]  w_lo_e, w_up_e;
            logic [COEF_W-1:0] w_lo_c, w_up_c;

            if (g == 0) begin : g_head
                assign w_lo_e = r_e;
                assign w_lo_c = r_c;
            end else begin : g_mid
                assign w_lo_e = w_exp[g-1];
                assign w_lo_c = w_coef[g-1];
            end
            if (g == MAX_TERMS - 1) begin : g_tail
                assign w_up_e = '0;
                assign w_up_c = '0;
            end else begin : g_body
                assign w_up_e = w_exp[g+1];
                assign w_up_c = w_coef[g+1];
            end

            spts_cell #(
                .CNT_W (CNT_W),
                .IDX   (g)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_cnt       (w_cnt),
                .i_cmp_exp   (w_in_exp),
                .i_cmp_pos   (w_in_pos),
                .i_new_coef  (r_c),
                .i_lo_exp    (w_lo_e),
                .i_lo_coef   (w_lo_c),
                .i_up_exp    (w_up_e),
                .i_up_coef   (w_up_c),
                .i_hit_pre   (w_pre[g]),
                .i_gath_exp  (w_gath_e[g]),
                .i_gath_coef (w_gath_c[g]),
                .o_exp       (w_exp[g]),
                .o_coef      (w_coef[g]),
                .o_hit       (w_hits[g]),
                .o_hit_pre   (w_pre[g+1]),
                .o_gath_exp  (w_gath_e[g+1]),
                .o_gath_coef (w_gath_c[g+1]),
                .o_leaf      (w_leaf[g])
            );
        end
    endgenerate

    spts_max_tree #(
        .NUM (MAX_TERMS)
    ) u_max_tree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_max  (w_degree)
    );

    assign m_axis_tdata = {(r_count == '0), w_degree, CNT_OUT_W'(r_count), r_eout, r_cout};
    assign m_axis_tuser = r_status;

    // ---- checks ----
    `SPTS_ASSERT(a_cnt_max, r_count <= FULL_CNT, "term count above capacity")
    `SPTS_ASSERT(a_hit_one, (r_state == S_APPLY) |-> $onehot0(w_hits),
                 "more than one slot matched")
    `SPTS_ASSERT_NEXT(a_cnt_hold, (r_state != S_APPLY) && !w_in_acc, $stable(r_count),
                      "term count moved outside apply")
    `SPTS_ASSERT(a_full_cnt, (m_axis_tvalid && m_axis_tuser == ST_FULL) |-> (r_count == FULL_CNT),
                 "full status with free slots")

endmodule

`default_nettype wire

// File: test/term_store_checker.sv
`timescale 1ns / 100ps
// Checker for the sparse polynomial term store: watches both stream channels,
// predicts each result from its own copy of the term list and compares them.
// Depends on spts_pkg for field widths, tdata layout, t_op and t_status.

module term_store_checker import spts_pkg::*; #(
    parameter int MAX_TERMS = 64
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_in_ready,
    // clear_first, negate, coef_in, exponent_in, position
    input  wire [IN_DATA_W-1:0]  i_in_data,
    // op
    input  wire                  i_in_op,
    input  wire                  i_out_valid,
    input  wire                  i_out_ready,
    // coef_out, exponent_out, term_count, degree, is_empty
    input  wire [OUT_DATA_W-1:0] i_out_data,
    // status
    input  wire [1:0]            i_out_status,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_results,
    output int                   o_full_drops
);

    localparam int OUT_EXP_LSB   = COEF_W;
    localparam int OUT_CNT_LSB   = OUT_EXP_LSB + EXP_W;
    localparam int OUT_DEG_LSB   = OUT_CNT_LSB + CNT_OUT_W;
    localparam int OUT_EMPTY_BIT = OUT_DEG_LSB + EXP_W;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [COEF_W-1:0]    coef;
        logic [EXP_W-1:0]     expo;
        logic [CNT_OUT_W-1:0] count;
        logic [EXP_W-1:0]     degree;
        logic                 empty;
        logic [1:0]           status;
    } t_term_result;

    // Term list, newest at index 0
    bit [EXP_W-1:0]  held_exp  [MAX_TERMS];
    bit [COEF_W-1:0] held_coef [MAX_TERMS];
    int              held_count = 0;

    t_term_result    expected_terms [$];
    int              fail_total = 0;
    int              result_total = 0;
    int              full_drop_total = 0;

    function automatic t_term_result predict_term_item(
        input t_op              op,
        input bit               clr,
        input bit               neg,
        input bit [COEF_W-1:0]  coef,
        input bit [EXP_W-1:0]   expo,
        input bit [POS_W-1:0]   pos
    );
        t_term_result    r;
        bit [COEF_W-1:0] addend;
        bit [COEF_W-1:0] sum;
        int              at;
        r = '0;
        r.status = ST_OK;
        at = -1;
        if (clr)
            held_count = 0;
        if (op == OP_PUT) begin
            addend = neg ? (0 - coef) : coef;
            r.expo = expo;
            for (int i = 0; i < held_count; i++)
                if (at < 0 && held_exp[i] == expo)
                    at = i;
            if (at >= 0) begin
                sum = held_coef[at] + addend;
                if (sum == 0) begin
                    // close the gap behind the removed term
                    for (int i = at; i < held_count - 1; i++) begin
                        held_exp[i]  = held_exp[i + 1];
                        held_coef[i] = held_coef[i + 1];
                    end
                    held_count--;
                end else begin
                    held_coef[at] = sum;
                    r.coef = sum;
                end
            end else if (addend != 0) begin
                if (held_count >= MAX_TERMS) begin
                    r.status = ST_FULL;
                    full_drop_total++;
                end else begin
                    for (int i = held_count; i > 0; i--) begin
                        held_exp[i]  = held_exp[i - 1];
                        held_coef[i] = held_coef[i - 1];
                    end
                    held_exp[0]  = expo;
                    held_coef[0] = addend;
                    held_count++;
                    r.coef = addend;
                end
            end
        end else if (int'(pos) < held_count) begin
            r.coef = held_coef[pos];
            r.expo = held_exp[pos];
        end else begin
            r.status = ST_RANGE;
        end
        for (int i = 0; i < held_count; i++)
            if (held_exp[i] > r.degree)
                r.degree = held_exp[i];
        r.count = held_count[CNT_OUT_W-1:0];
        r.empty = (held_count == 0);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_term_result want;
        t_term_result got;
        if (!i_rst_n) begin
            held_count = 0;
            expected_terms.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                got.coef   = i_out_data[0 +: COEF_W];
                got.expo   = i_out_data[OUT_EXP_LSB +: EXP_W];
                got.count  = i_out_data[OUT_CNT_LSB +: CNT_OUT_W];
                got.degree = i_out_data[OUT_DEG_LSB +: EXP_W];
                got.empty  = i_out_data[OUT_EMPTY_BIT];
                got.status = i_out_status;
                if (expected_terms.size() == 0) begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("%0t: unexpected result beat: coef %h exp %0d count %0d",
                                 $time, got.coef, got.expo, got.count);
                end else begin
                    want = expected_terms.pop_front();
                    result_total++;
                    if (got.coef !== want.coef || got.expo !== want.expo
                        || got.count !== want.count || got.degree !== want.degree
                        || got.empty !== want.empty || got.status !== want.status) begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT) begin
                            $display("%0t: mismatch on result %0d", $time, result_total);
                            $display("  expected coef %h exp %0d count %0d deg %0d empty %0d st %0d",
                                     want.coef, want.expo, want.count, want.degree,
                                     want.empty, want.status);
                            $display("  actual   coef %h exp %0d count %0d deg %0d empty %0d st %0d",
                                     got.coef, got.expo, got.count, got.degree,
                                     got.empty, got.status);
                        end
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_terms.push_back(predict_term_item(
                    t_op'(i_in_op),
                    i_in_data[IN_CLR_LSB],
                    i_in_data[IN_NEG_LSB],
                    i_in_data[IN_COEF_LSB +: COEF_W],
                    i_in_data[IN_EXP_LSB +: EXP_W],
                    i_in_data[IN_POS_LSB +: POS_W]));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_terms.size();
        o_results    <= result_total;
        o_full_drops <= full_drop_total;
    end

endmodule

// File: test/tb.sv
`timescale 1ns / 100ps
// Top of the term store testbench: clock, reset, stimulus and verdict.
// Depends on spts_pkg, sparse_polynomial_term_store and term_store_checker.

module tb import spts_pkg::*; ();

    localparam int MAX_TERMS      = 64;
    localparam int ITEM_TARGET    = 1250;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    t_op                   s_user = OP_PUT;
    wire                   s_ready;
    wire                   m_valid;
    logic                  m_ready = 1'b0;
    wire [OUT_DATA_W-1:0]  m_data;
    wire [1:0]             m_user;

    int fails;
    int pending;
    int results;
    int full_drops;

    int items_sent = 0;
    int snd_idle_pct = 0;
    int rcv_idle_pct = 0;
    int holds_requested = 0;
    int holds_done = 0;
    int hold_left = 0;

    always #2 clk = ~clk;

    sparse_polynomial_term_store #(.MAX_TERMS(MAX_TERMS)) dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .s_axis_tuser  (s_user),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tuser  (m_user)
    );

    term_store_checker #(.MAX_TERMS(MAX_TERMS)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_in_op      (s_user),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_status (m_user),
        .o_fail_count (fails),
        .o_pending    (pending),
        .o_results    (results),
        .o_full_drops (full_drops)
    );

    // Receiver: random stalls, or a long hold-off when one is requested
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done != holds_requested) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Stop the run when no beat moves on either side for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge clk);
            if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet, pending);
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    function automatic bit [COEF_W-1:0] pick_coef();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2, 3:    return $urandom;
            default: return 32'($urandom_range(6)) - 32'd3;
        endcase
    endfunction

    // Offer one beat, idling first at the current sender rate; valid stays high
    task automatic send_item(input t_op op, input bit clr, input bit neg,
                             input bit [COEF_W-1:0] coef, input bit [EXP_W-1:0] expo,
                             input bit [POS_W-1:0] pos);
        while ($urandom_range(99) < snd_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {pos, expo, coef, neg, clr};
        @(posedge clk);
        while (!s_ready)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_all_results();
        s_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    // Fill the store to near or past its capacity, then read, update, add (dropped when full) and remove
    task automatic run_fill();
        int              n;
        bit [EXP_W-1:0]  e;
        bit [COEF_W-1:0] c;
        bit [EXP_W-1:0]  kept_exp [2];
        bit [COEF_W-1:0] kept_coef [2];
        n = $urandom_range(62, 72);
        for (int i = 0; i < n; i++) begin
            e = $urandom;
            c = $urandom;
            if (c == 0)
                c = 1;
            if (i < 2) begin
                kept_exp[i]  = e;
                kept_coef[i] = c;
            end
            send_item(OP_PUT, i == 0, 1'b0, c, e, 6'($urandom));
        end
        for (int i = 0; i < 3; i++)
            send_item(OP_READ, 1'b0, 1'($urandom_range(1)), $urandom, 16'($urandom),
                      6'($urandom));
        send_item(OP_PUT, 1'b0, 1'($urandom_range(1)), pick_coef(), kept_exp[0], 6'd0);
        send_item(OP_PUT, 1'b0, 1'b0, 32'h0000_1234, 16'($urandom), 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, kept_coef[1], kept_exp[1], 6'd0);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd63);
    endtask

    task automatic run_random_until(input int target);
        int              r;
        int              n;
        bit [EXP_W-1:0]  e;
        bit [EXP_W-1:0]  base;
        bit [COEF_W-1:0] c [4];
        while (items_sent < target) begin
            r = $urandom_range(99);
            if (r < 8) begin
                run_fill();
            end else if (r < 80) begin
                // short polynomial over a mostly small exponent pool, coefficients mostly near zero
                n = $urandom_range(4, 20);
                for (int i = 0; i < n; i++) begin
                    r = $urandom_range(99);
                    if (r < 60) begin
                        e = ($urandom_range(4) == 0) ? 16'($urandom) : 16'($urandom_range(15));
                        send_item(OP_PUT, i == 0 && $urandom_range(9) < 7,
                                  1'($urandom_range(1)), pick_coef(), e, 6'($urandom));
                    end else if (r < 88) begin
                        send_item(OP_READ, 1'b0, 1'($urandom_range(1)), $urandom,
                                  16'($urandom), 6'($urandom_range(20)));
                    end else begin
                        send_item(t_op'($urandom_range(1)), $urandom_range(7) == 0,
                                  1'($urandom_range(1)), $urandom, 16'($urandom),
                                  6'($urandom));
                    end
                end
            end else if (r < 92) begin
                // four terms, then cancel the middle, the head and the tail
                base = 16'($urandom_range(65531));
                for (int k = 0; k < 4; k++) begin
                    c[k] = pick_coef();
                    if (c[k] == 0)
                        c[k] = 1;
                    send_item(OP_PUT, k == 0, 1'b0, c[k], base + 16'(k), 6'd0);
                end
                if ($urandom_range(1))
                    send_item(OP_PUT, 1'b0, 1'b1, c[1], base + 16'd1, 6'd0);
                else
                    send_item(OP_PUT, 1'b0, 1'b0, 0 - c[1], base + 16'd1, 6'd0);
                for (int k = 0; k < 4; k++)
                    send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'(k));
                send_item(OP_PUT, 1'b0, 1'b1, c[3], base + 16'd3, 6'd0);
                send_item(OP_PUT, 1'b0, 1'b0, 0 - c[0], base, 6'd0);
                send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd0);
            end else begin
                for (int i = 0; i < 3; i++)
                    send_item(t_op'($urandom_range(1)), $urandom_range(7) == 0,
                              1'($urandom_range(1)), $urandom, 16'($urandom), 6'($urandom));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        snd_idle_pct = 18;
        rcv_idle_pct <= 59;
        // empty store, coefficient extremes and wrap, zero puts, removals, clears
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b0, 32'd1, 16'd0, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b0, 32'h7FFF_FFFF, 16'hFFFF, 6'h3F);
        send_item(OP_PUT, 1'b0, 1'b0, 32'd1, 16'hFFFF, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, 32'h8000_0000, 16'hFFFF, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b0, 32'd0, 16'd7, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, 32'd0, 16'd9, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, 32'h8000_0000, 16'd7, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, 32'hFFFF_FFFF, 16'd300, 6'd0);
        send_item(OP_READ, 1'b0, 1'b0, 32'hFFFF_FFFF, 16'hFFFF, 6'd0);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd2);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd3);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd63);
        send_item(OP_PUT, 1'b0, 1'b0, 32'h8000_0000, 16'd7, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b1, 32'd1, 16'd0, 6'd0);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd0);
        send_item(OP_PUT, 1'b1, 1'b0, 32'd5, 16'd3, 6'd0);
        send_item(OP_READ, 1'b1, 1'b0, 32'd0, 16'd0, 6'd0);
        send_item(OP_PUT, 1'b1, 1'b1, 32'h7FFF_FFFF, 16'hFFFF, 6'd0);
        send_item(OP_PUT, 1'b0, 1'b0, 32'h7FFF_FFFF, 16'hFFFF, 6'd0);
        send_item(OP_READ, 1'b0, 1'b0, 32'd0, 16'd0, 6'd0);
        run_fill();
        run_random_until(420);
        wait_all_results();

        snd_idle_pct = 59;
        rcv_idle_pct <= 18;
        run_random_until(840);
        wait_all_results();

        // no idling; hold the output long enough to back up the input
        snd_idle_pct = 0;
        rcv_idle_pct <= 0;
        holds_requested <= holds_requested + 1;
        run_random_until(items_sent + 40);
        run_random_until(ITEM_TARGET);

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items under three idle patterns and a %0d-cycle output hold-off;",
                 items_sent, HOLD_CYCLES);
        $display("checked %0d results, %0d puts dropped on a full store, %0d mismatches.",
                 results, full_drops, fails);
        if (fails == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
